// ----- design/owtrs_pkg.sv -----
`timescale 1ns / 1ps

package owtrs_pkg;

  localparam int SCRATCHPAD_LEN_DEF = 9;

  localparam logic [7:0] SKIP_ROM_CODE = 8'hCC;
  localparam logic [7:0] CONVERT_CODE  = 8'h44;
  localparam logic [7:0] READ_PAD_CODE = 8'hBE;
  localparam logic [7:0] NO_TX_CODE    = 8'h00;
  localparam logic [6:0] POLL_BITS     = 7'd8;
  localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_PRES1      = 3'd1,
    PH_POLL       = 3'd2,
    PH_CHECK_POLL = 3'd3,
    PH_PRES2      = 3'd4,
    PH_READ       = 3'd5,
    PH_CRC        = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_TX    = 2'd2,
    CMD_RX    = 2'd3
  } cmd_t;

  // Dallas/Maxim CRC-8, reflected, one byte folded in
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- design/onewire_temp_read_sequencer.sv -----
`timescale 1ns / 1ps

// 1-Wire temperature read sequencer. Every beat on the input channel is one
// event from a 1-Wire bus driver: action 0 means the driver is ready for its
// next command and always yields exactly one result beat (command, transmit
// bytes, bit count, temperature, update flag, busy LED); action 1 carries one
// received byte and yields nothing. The sequence is reset, Skip ROM + Convert,
// 8-bit polls until a nonzero byte, reset, Skip ROM + Read Scratchpad, then a
// SCRATCHPAD_LEN-byte read whose CRC-8 is checked against the last byte. A
// match latches the 16-bit temperature (bytes 0 and 1) and drops the busy LED;
// a mismatch or short read retries from the second reset; a bus error flagged
// with a ready event restarts from the first reset. Throughput is one beat per
// clock: the sequencer state and the bytewise CRC update as each beat is taken and
// the result sits in one output register, so the input stalls only while that
// register is full and the output side is stalled. A ready beat's result is
// registered and valid in the next cycle. No clearing pass after reset.
module onewire_temp_read_sequencer #(
  parameter int SCRATCHPAD_LEN = owtrs_pkg::SCRATCHPAD_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic               presence,
  input  logic               bus_error,
  input  logic [7:0]         rx_data,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         command,
  output logic [7:0]         tx_first,
  output logic [7:0]         tx_second,
  output logic [6:0]         rx_bit_count,
  output logic signed [15:0] temperature,
  output logic               temp_updated,
  output logic               busy_led
);

  localparam int IDX_W   = $clog2(SCRATCHPAD_LEN + 1);
  localparam int ADDR_W  = $clog2(SCRATCHPAD_LEN);
  localparam int RX_BITS = SCRATCHPAD_LEN * 8;

  localparam logic [IDX_W-1:0] IDX_FULL = IDX_W'(SCRATCHPAD_LEN);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SCRATCHPAD_LEN - 1);
  localparam logic [6:0]       PAD_BITS = 7'(RX_BITS);  // masked to 7 bits

  // sequencer state
  owtrs_pkg::phase_t phase, phase_next, phase_eff;
  logic [IDX_W-1:0]  byte_index;
  logic [7:0]        crc_accum;
  logic [7:0]        scratchpad [SCRATCHPAD_LEN];
  logic [15:0]       temp_reg, temp_reg_next;
  logic              led_flag, led_flag_next;

  // per-event decode
  logic              in_fire, ready_beat, byte_beat;
  logic              start_rx, crc_ok, poll_done;
  owtrs_pkg::cmd_t   cmd_c;
  logic [7:0]        tx1_c, tx2_c;
  logic [6:0]        nbits_c;
  logic              updated_c;

  // the result register is the only thing that can hold the input back
  assign in_stall   = out_valid & out_stall;
  assign in_fire    = in_valid & ~in_stall;
  assign ready_beat = in_fire & ~action;
  assign byte_beat  = in_fire & action;

  // a bus error sends the sequence back to the first reset
  assign phase_eff = bus_error ? owtrs_pkg::PH_IDLE : phase;

  assign poll_done = (byte_index != '0) && (scratchpad[0] != 8'h00);
  assign crc_ok    = (byte_index >= IDX_FULL) &&
                     (crc_accum == scratchpad[SCRATCHPAD_LEN-1]);

  // next state
  always_comb begin
    phase_next = phase_eff;
    case (phase_eff)
      owtrs_pkg::PH_PRES1:
        phase_next = presence ? owtrs_pkg::PH_POLL : owtrs_pkg::PH_IDLE;
      owtrs_pkg::PH_POLL:
        phase_next = owtrs_pkg::PH_CHECK_POLL;
      owtrs_pkg::PH_CHECK_POLL:
        phase_next = poll_done ? owtrs_pkg::PH_PRES2 : owtrs_pkg::PH_POLL;
      owtrs_pkg::PH_PRES2:
        phase_next = presence ? owtrs_pkg::PH_READ : owtrs_pkg::PH_IDLE;
      owtrs_pkg::PH_READ:
        phase_next = owtrs_pkg::PH_CRC;
      owtrs_pkg::PH_CRC:
        phase_next = crc_ok ? owtrs_pkg::PH_IDLE : owtrs_pkg::PH_PRES2;
      default:
        phase_next = owtrs_pkg::PH_PRES1;  // idle and the spare code
    endcase
  end

  // command and side effects of a ready event
  always_comb begin
    cmd_c         = owtrs_pkg::CMD_NONE;
    tx1_c         = owtrs_pkg::NO_TX_CODE;
    tx2_c         = owtrs_pkg::NO_TX_CODE;
    nbits_c       = '0;
    updated_c     = 1'b0;
    start_rx      = 1'b0;
    led_flag_next = led_flag;
    temp_reg_next = temp_reg;
    case (phase_eff)
      owtrs_pkg::PH_PRES1: begin
        if (presence) begin
          led_flag_next = 1'b1;
          cmd_c         = owtrs_pkg::CMD_TX;
          tx1_c         = owtrs_pkg::SKIP_ROM_CODE;
          tx2_c         = owtrs_pkg::CONVERT_CODE;
        end
      end
      owtrs_pkg::PH_POLL: begin
        start_rx = 1'b1;
        cmd_c    = owtrs_pkg::CMD_RX;
        nbits_c  = owtrs_pkg::POLL_BITS;
      end
      owtrs_pkg::PH_CHECK_POLL: begin
        if (poll_done) begin
          cmd_c = owtrs_pkg::CMD_RESET;
        end
      end
      owtrs_pkg::PH_PRES2: begin
        if (presence) begin
          cmd_c = owtrs_pkg::CMD_TX;
          tx1_c = owtrs_pkg::SKIP_ROM_CODE;
          tx2_c = owtrs_pkg::READ_PAD_CODE;
        end
      end
      owtrs_pkg::PH_READ: begin
        start_rx = 1'b1;
        cmd_c    = owtrs_pkg::CMD_RX;
        nbits_c  = PAD_BITS;
      end
      owtrs_pkg::PH_CRC: begin
        if (crc_ok) begin
          temp_reg_next = {scratchpad[1], scratchpad[0]};
          updated_c     = 1'b1;
          led_flag_next = 1'b0;
        end else begin
          cmd_c = owtrs_pkg::CMD_RESET;
        end
      end
      default: begin
        cmd_c = owtrs_pkg::CMD_RESET;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= owtrs_pkg::PH_IDLE;
      byte_index <= '0;
      crc_accum  <= '0;
      temp_reg   <= '0;
      led_flag   <= 1'b0;
    end else if (ready_beat) begin
      phase    <= phase_next;
      temp_reg <= temp_reg_next;
      led_flag <= led_flag_next;
      if (start_rx) begin
        byte_index <= '0;
        crc_accum  <= '0;
      end
    end else if (byte_beat && (byte_index < IDX_FULL)) begin
      // bytes past the end of the scratchpad are dropped
      byte_index <= byte_index + 1'b1;
      if (byte_index < IDX_LAST) begin
        crc_accum <= owtrs_pkg::crc8_byte(crc_accum, rx_data);
      end
    end
  end

  // scratchpad bytes, stored whatever the phase
  always_ff @(posedge clk) begin
    if (byte_beat && (byte_index < IDX_FULL)) begin
      scratchpad[byte_index[ADDR_W-1:0]] <= rx_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready_beat) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_beat) begin
      command      <= cmd_c;
      tx_first     <= tx1_c;
      tx_second    <= tx2_c;
      rx_bit_count <= nbits_c;
      temperature  <= $signed(temp_reg_next);
      temp_updated <= updated_c;
      busy_led     <= led_flag_next;
    end
  end

  // checks
  a_ready_gives_result: assert property (@(posedge clk) disable iff (rst)
    ready_beat |=> out_valid)
    else $error("ready beat did not produce a result");

  a_update_clears_led: assert property (@(posedge clk) disable iff (rst)
    (out_valid && temp_updated) |-> (!busy_led && command == owtrs_pkg::CMD_NONE))
    else $error("temperature update with busy LED or a command");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    byte_index <= IDX_FULL)
    else $error("byte index past scratchpad length");

  a_tx_skip_rom: assert property (@(posedge clk) disable iff (rst)
    (out_valid && command == owtrs_pkg::CMD_TX) |-> (tx_first == owtrs_pkg::SKIP_ROM_CODE))
    else $error("transmit without Skip ROM code");

  a_byte_no_result: assert property (@(posedge clk) disable iff (rst)
    (byte_beat && !out_valid) |=> !out_valid)
    else $error("byte beat produced a result");

endmodule
